/* design/dda_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DDA line rasterizer package
// Shared widths and command codes for the line rasterizer.
// ----------------------------------------------------------------------------
package dda_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int COLOR_BITS     = 32;

  localparam logic FUNC_START   = 1'b0;
  localparam logic FUNC_ADVANCE = 1'b1;

endpackage

/* design/dda_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DDA line rasterizer channels
// Valid/ready channels for line commands and emitted pixels.
// ----------------------------------------------------------------------------
interface dda_cmd_if #(
  parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF
);
  logic                            valid;
  logic                            ready;
  logic                            func;
  logic [COORD_BITS-1:0]           x_start;
  logic [COORD_BITS-1:0]           y_start;
  logic [COORD_BITS-1:0]           x_end;
  logic [COORD_BITS-1:0]           y_end;
  logic [dda_pkg::COLOR_BITS-1:0]  pen_color;

  modport source (
    output valid, func, x_start, y_start, x_end, y_end, pen_color,
    input  ready
  );
  modport sink (
    input  valid, func, x_start, y_start, x_end, y_end, pen_color,
    output ready
  );
endinterface

interface dda_pix_if #(
  parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF
);
  logic                            valid;
  logic                            ready;
  logic [COORD_BITS-1:0]           pixel_x;
  logic [COORD_BITS-1:0]           pixel_y;
  logic [dda_pkg::COLOR_BITS-1:0]  pixel_color;
  logic                            last;

  modport source (
    output valid, pixel_x, pixel_y, pixel_color, last,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, pixel_color, last,
    output ready
  );
endinterface

/* design/dda_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DDA line stepper
// Holds the line state, sets it up on a start command and produces one
// pixel per advance command with an exact integer error term.
// ----------------------------------------------------------------------------
module dda_core #(
  parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           fire,
  input  logic                           func,
  input  logic [COORD_BITS-1:0]          x_start,
  input  logic [COORD_BITS-1:0]          y_start,
  input  logic [COORD_BITS-1:0]          x_end,
  input  logic [COORD_BITS-1:0]          y_end,
  input  logic [dda_pkg::COLOR_BITS-1:0] pen_color,
  output logic                           push,
  output logic [COORD_BITS-1:0]          pixel_x,
  output logic [COORD_BITS-1:0]          pixel_y,
  output logic [dda_pkg::COLOR_BITS-1:0] pixel_color,
  output logic                           last
);
  import dda_pkg::*;

  localparam int ERR_BITS = COORD_BITS + 3;

  logic                         active;
  logic                         axes_swapped;
  logic                         minor_up;
  logic [COORD_BITS-1:0]        major_pos;
  logic [COORD_BITS-1:0]        major_stop;
  logic [COORD_BITS-1:0]        minor_pos;
  logic [COORD_BITS-1:0]        major_len;
  logic [COORD_BITS-1:0]        minor_len;
  logic signed [ERR_BITS-1:0]   error_term;
  logic [COLOR_BITS-1:0]        line_color;

  logic                         start;
  logic                         advance;

  // line setup
  logic [COORD_BITS-1:0]        dx;
  logic [COORD_BITS-1:0]        dy;
  logic                         steep;
  logic [COORD_BITS-1:0]        pa;
  logic [COORD_BITS-1:0]        qa;
  logic [COORD_BITS-1:0]        pb;
  logic [COORD_BITS-1:0]        qb;
  logic                         flip;
  logic [COORD_BITS-1:0]        mj_lo;
  logic [COORD_BITS-1:0]        mj_hi;
  logic [COORD_BITS-1:0]        mn_lo;
  logic [COORD_BITS-1:0]        mn_hi;

  // stepping
  logic signed [ERR_BITS:0]     err2;
  logic signed [ERR_BITS:0]     len2;
  logic signed [ERR_BITS-1:0]   major_ext;
  logic signed [ERR_BITS-1:0]   minor_ext;
  logic                         step;
  logic [COORD_BITS-1:0]        minor_cur;
  logic signed [ERR_BITS-1:0]   err_mid;
  logic signed [ERR_BITS-1:0]   error_term_next;
  logic                         at_stop;

  assign start   = fire && (func == FUNC_START);
  assign advance = fire && (func == FUNC_ADVANCE) && active;

  always_comb begin
    dx    = (x_start > x_end) ? x_start - x_end : x_end - x_start;
    dy    = (y_start > y_end) ? y_start - y_end : y_end - y_start;
    steep = dx < dy;
    pa    = steep ? y_start : x_start;
    qa    = steep ? x_start : y_start;
    pb    = steep ? y_end   : x_end;
    qb    = steep ? x_end   : y_end;
    flip  = pb < pa;
    mj_lo = flip ? pb : pa;
    mj_hi = flip ? pa : pb;
    mn_lo = flip ? qb : qa;
    mn_hi = flip ? qa : qb;
  end

  always_comb begin
    major_ext       = $signed({{(ERR_BITS-COORD_BITS){1'b0}}, major_len});
    minor_ext       = $signed({{(ERR_BITS-COORD_BITS){1'b0}}, minor_len});
    err2            = $signed({error_term, 1'b0});
    len2            = $signed({{(ERR_BITS+1-COORD_BITS){1'b0}}, major_len});
    step            = err2 > len2;
    if (!step) begin
      minor_cur = minor_pos;
    end else if (minor_up) begin
      minor_cur = minor_pos + 1'b1;
    end else begin
      minor_cur = minor_pos - 1'b1;
    end
    err_mid         = step ? error_term - major_ext : error_term;
    error_term_next = err_mid + minor_ext;
    at_stop         = major_pos == major_stop;
  end

  assign push        = advance;
  assign pixel_x     = axes_swapped ? minor_cur : major_pos;
  assign pixel_y     = axes_swapped ? major_pos : minor_cur;
  assign pixel_color = line_color;
  assign last        = at_stop;

  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      axes_swapped <= 1'b0;
      minor_up     <= 1'b0;
    end else if (start) begin
      active       <= 1'b1;
      axes_swapped <= steep;
      minor_up     <= mn_lo < mn_hi;
    end else if (advance && at_stop) begin
      active       <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      major_pos  <= mj_lo;
      major_stop <= mj_hi;
      minor_pos  <= mn_lo;
      major_len  <= mj_hi - mj_lo;
      minor_len  <= (mn_lo > mn_hi) ? mn_lo - mn_hi : mn_hi - mn_lo;
      error_term <= '0;
      line_color <= pen_color;
    end else if (advance) begin
      minor_pos  <= minor_cur;
      error_term <= error_term_next;
      if (!at_stop) begin
        major_pos <= major_pos + 1'b1;
      end
    end
  end

endmodule

/* design/dda_obuf.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DDA output buffer
// Output register with a skid stage so a pixel can be taken in while the
// previous one waits for its transfer.
// ----------------------------------------------------------------------------
module dda_obuf #(
  parameter int WIDTH = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             room,
  input  logic             ready,
  output logic             valid,
  output logic [WIDTH-1:0] data
);
  logic             skid_valid;
  logic [WIDTH-1:0] skid_data;
  logic             take;

  assign take = !valid || ready;
  assign room = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take) begin
      valid      <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

/* design/dda_line_rasterizer.sv */
`timescale 1ns / 1ps
// A pixel from an advance transfer is registered in the output register, or in the skid entry while the output stalls.
// Throughput: one command per cycle while the output stage has room; each advance is one compare and add
// on the error term, done in the cycle of its transfer.
// A two-entry output stage (register plus skid) decouples the output side.
// Reset clears the line state and the output stage; no clearing pass.
// ----------------------------------------------------------------------------
// DDA line rasterizer
// Walks a line between two endpoints and emits one pixel per advance.
// ----------------------------------------------------------------------------
module dda_line_rasterizer #(
  parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  dda_cmd_if.sink   cmd,
  dda_pix_if.source pix
);
  import dda_pkg::*;

  localparam int PIX_BITS = 2 * COORD_BITS + COLOR_BITS + 1;

  logic                  fire;
  logic                  push;
  logic [COORD_BITS-1:0] push_x;
  logic [COORD_BITS-1:0] push_y;
  logic [COLOR_BITS-1:0] push_color;
  logic                  push_last;
  logic                  room;
  logic [PIX_BITS-1:0]   out_data;

  assign fire      = cmd.valid && cmd.ready;
  assign cmd.ready = room;

  dda_core #(
    .COORD_BITS (COORD_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .func        (cmd.func),
    .x_start     (cmd.x_start),
    .y_start     (cmd.y_start),
    .x_end       (cmd.x_end),
    .y_end       (cmd.y_end),
    .pen_color   (cmd.pen_color),
    .push        (push),
    .pixel_x     (push_x),
    .pixel_y     (push_y),
    .pixel_color (push_color),
    .last        (push_last)
  );

  dda_obuf #(
    .WIDTH (PIX_BITS)
  ) u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_x, push_y, push_color, push_last}),
    .room      (room),
    .ready     (pix.ready),
    .valid     (pix.valid),
    .data      (out_data)
  );

  assign pix.pixel_x     = out_data[PIX_BITS-1 -: COORD_BITS];
  assign pix.pixel_y     = out_data[PIX_BITS-COORD_BITS-1 -: COORD_BITS];
  assign pix.pixel_color = out_data[COLOR_BITS:1];
  assign pix.last        = out_data[0];

`ifndef NO_ASSERTIONS
  a_push_on_advance: assert property (@(posedge clk) disable iff (rst)
    push |-> fire && (cmd.func == FUNC_ADVANCE))
    else $error("pixel produced without an advance transfer");

  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    push && push_last |=> !push)
    else $error("pixel produced after the final pixel of a line");

  a_stall_means_full: assert property (@(posedge clk) disable iff (rst)
    !cmd.ready |-> pix.valid)
    else $error("command side stalled while the output is empty");
`endif

endmodule
